// ===== rtl/core/swsr_pkg.sv =====
// Shared constants and types for the single-wire sensor receiver.
`timescale 1ns / 1ps
`default_nettype none

package swsr_pkg;

  localparam int FRAME_BITS     = 40;
  localparam int TEMP_FIRST_BIT = 16;
  localparam int COUNT_WIDTH    = 16;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int BIT_W      = $clog2(FRAME_BITS + 1);
  localparam int CMP_W      = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_START_LOW  = 3'd0,
    CFG_TIMEOUT    = 3'd1,
    CFG_ZERO_LOW   = 3'd2,
    CFG_ZERO_HIGH  = 3'd3,
    CFG_ONE_LOW    = 3'd4,
    CFG_ONE_HIGH   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] start_low_ticks;
    logic [CFG_DATA_W-1:0] timeout_ticks;
    logic [CFG_DATA_W-1:0] zero_width_low;
    logic [CFG_DATA_W-1:0] zero_width_high;
    logic [CFG_DATA_W-1:0] one_width_low;
    logic [CFG_DATA_W-1:0] one_width_high;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       status;
    logic [7:0] temperature;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/single_wire_sensor_receiver_unit.sv =====
// Top level of the single-wire sensor receiver: input and result registers around the sequencer.
// Data path: each word is decoded from the input register into the result register.
// Throughput: one input word and one result word per cycle unless out_stall_i holds a full
//   result register; the sequencer state advances once per word, between the two registers.
// Reset (rst_ni low, asynchronous): phase idle, counters and temperature cleared,
//   configuration back to its default values; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module single_wire_sensor_receiver_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            start_request_i,
  input  wire logic                            line_level_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 drive_low_o,
  output logic                                 busy_res_o,
  output logic                                 done_res_o,
  output logic                                 status_o,
  output logic [7:0]                           temperature_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [swsr_pkg::CFG_ADDR_W-1:0] cfg_index_i,
  input  wire logic [swsr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  swsr_pkg::cfg_t cfg;
  swsr_pkg::res_t res;
  swsr_pkg::res_t res_q;

  logic in_valid_q;
  logic start_q, line_q;
  logic out_valid_q;
  logic out_adv;
  logic fire;

  // result register frees up when empty or when its word is taken
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      start_q <= start_request_i;
      line_q  <= line_level_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  swsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  swsr_fsm u_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .start_request_i (start_q),
    .line_level_i    (line_q),
    .cfg_i           (cfg),
    .res_o           (res)
  );

  assign out_valid_o   = out_valid_q;
  assign drive_low_o   = res_q.drive_low;
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign status_o      = res_q.status;
  assign temperature_o = res_q.temperature;

endmodule

`default_nettype wire

// ===== rtl/core/swsr_cfg.sv =====
// Configuration register file of the single-wire sensor receiver.
`timescale 1ns / 1ps
`default_nettype none

module swsr_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [swsr_pkg::CFG_ADDR_W-1:0] cfg_index_i,
  input  wire logic [swsr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output swsr_pkg::cfg_t                       cfg_o
);

  swsr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks <= 16'd18000;
      cfg_q.timeout_ticks   <= 16'd500;
      cfg_q.zero_width_low  <= 16'd20;
      cfg_q.zero_width_high <= 16'd30;
      cfg_q.one_width_low   <= 16'd60;
      cfg_q.one_width_high  <= 16'd80;
    end else if (cfg_we_i) begin
      case (swsr_pkg::cfg_idx_e'(cfg_index_i))
        swsr_pkg::CFG_START_LOW: cfg_q.start_low_ticks <= cfg_data_i;
        swsr_pkg::CFG_TIMEOUT:   cfg_q.timeout_ticks   <= cfg_data_i;
        swsr_pkg::CFG_ZERO_LOW:  cfg_q.zero_width_low  <= cfg_data_i;
        swsr_pkg::CFG_ZERO_HIGH: cfg_q.zero_width_high <= cfg_data_i;
        swsr_pkg::CFG_ONE_LOW:   cfg_q.one_width_low   <= cfg_data_i;
        swsr_pkg::CFG_ONE_HIGH:  cfg_q.one_width_high  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/swsr_fsm.sv =====
// Read sequencer: phase state, pulse timing, bit decode and temperature capture.
`timescale 1ns / 1ps
`default_nettype none

module swsr_fsm (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire logic           start_request_i,
  input  wire logic           line_level_i,
  input  wire swsr_pkg::cfg_t cfg_i,
  output swsr_pkg::res_t      res_o
);

  localparam int CW = swsr_pkg::COUNT_WIDTH;
  localparam int BW = swsr_pkg::BIT_W;
  localparam int XW = swsr_pkg::CMP_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_WAIT_HIGH,
    PH_RESP_LOW,
    PH_RESP_HIGH,
    PH_BIT_LOW,
    PH_BIT_HIGH
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [BW-1:0]   bit_q, bit_d;
  logic [7:0]      shift_q, shift_d;
  logic            last_q, last_d;
  logic [7:0]      hold_q, hold_d;

  logic            drive, done, stat;
  logic            awaited;
  logic [CW-1:0]   cnt_inc;
  logic [XW-1:0]   cnt_x, inc_x, width_x;
  logic            new_bit;
  logic [7:0]      shift_new;
  logic [BW-1:0]   bit_inc;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    last_d  = last_q;
    hold_d  = hold_q;
    drive   = 1'b0;
    done    = 1'b0;
    stat    = 1'b0;

    awaited = !((phase_q == PH_RESP_LOW) || (phase_q == PH_BIT_LOW));
    cnt_inc = (cnt_q != swsr_pkg::CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
    cnt_x   = XW'(cnt_q);
    inc_x   = XW'(cnt_inc);
    width_x = cnt_x;

    // zero window wins when the windows overlap; outside both keeps last bit
    if ((width_x > XW'(cfg_i.zero_width_low)) && (width_x < XW'(cfg_i.zero_width_high))) begin
      new_bit = 1'b0;
    end else if ((width_x > XW'(cfg_i.one_width_low)) &&
                 (width_x < XW'(cfg_i.one_width_high))) begin
      new_bit = 1'b1;
    end else begin
      new_bit = last_q;
    end

    if ((bit_q >= BW'(swsr_pkg::TEMP_FIRST_BIT)) &&
        (bit_q < BW'(swsr_pkg::TEMP_FIRST_BIT + 8))) begin
      shift_new = {shift_q[6:0], new_bit};
    end else begin
      shift_new = shift_q;
    end
    bit_inc = bit_q + 1'b1;

    case (phase_q)
      PH_IDLE: begin
        if (start_request_i) begin
          phase_d = PH_START;
          cnt_d   = CW'(1);
          bit_d   = '0;
          shift_d = '0;
          last_d  = 1'b0;
          drive   = 1'b1;
        end
      end
      PH_START: begin
        if ((cnt_x < XW'(cfg_i.start_low_ticks)) && (cnt_q != swsr_pkg::CNT_MAX)) begin
          cnt_d = cnt_inc;
          drive = 1'b1;
        end else begin
          // release tick: its sample is not used
          phase_d = PH_WAIT_HIGH;
          cnt_d   = '0;
        end
      end
      default: begin
        if (line_level_i == awaited) begin
          if (inc_x > XW'(cfg_i.timeout_ticks)) begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
            done    = 1'b1;
            stat    = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          cnt_d = '0;
          case (phase_q)
            PH_WAIT_HIGH: phase_d = PH_RESP_LOW;
            PH_RESP_LOW:  phase_d = PH_RESP_HIGH;
            PH_RESP_HIGH: phase_d = PH_BIT_LOW;
            PH_BIT_LOW:   phase_d = PH_BIT_HIGH;
            default: begin
              last_d  = new_bit;
              shift_d = shift_new;
              bit_d   = bit_inc;
              if (bit_inc >= BW'(swsr_pkg::FRAME_BITS)) begin
                hold_d  = shift_new;
                phase_d = PH_IDLE;
                done    = 1'b1;
              end else begin
                phase_d = PH_BIT_LOW;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      last_q  <= 1'b0;
      hold_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      last_q  <= last_d;
      hold_q  <= hold_d;
    end
  end

  assign res_o.drive_low   = drive;
  assign res_o.busy_res    = (phase_d != PH_IDLE);
  assign res_o.done_res    = done;
  assign res_o.status      = stat;
  assign res_o.temperature = hold_d;

  // a finishing word always reports the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_res |-> !res_o.busy_res)
    else $error("done with busy set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.status |-> res_o.done_res)
    else $error("timeout status without done");

  // held temperature moves only on a good frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(hold_q) |-> $past(fire_i && res_o.done_res && !res_o.status))
    else $error("temperature changed outside a good read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BIT_HIGH) |-> (bit_q < BW'(swsr_pkg::FRAME_BITS)))
    else $error("bit index ran past the frame");

endmodule

`default_nettype wire
